@@ rtl/core/twba_pkg.sv @@
// ----------------------------------------------------------------------------
// twba_pkg
// Shared types and constants for the trade window bar aggregator: payload
// structs of both channels, divider request/response structs, widths.
// ----------------------------------------------------------------------------
package twba_pkg;

  localparam int TIME_BITS          = 48;
  localparam int FIELD_PRICE_BITS   = 32;
  localparam int FIELD_QTY_BITS     = 32;
  localparam int QSUM_BITS          = 48;
  localparam int NOTIONAL_BITS      = 64;
  localparam int TALLY_BITS         = 32;
  localparam int CFG_BITS           = 17;
  localparam int WIN_MS_BITS        = 27;
  localparam int MS_PER_SECOND      = 1000;

  localparam int DEF_PRICE_BITS     = 32;
  localparam int DEF_QUANTITY_BITS  = 32;

  localparam logic [CFG_BITS-1:0] WINDOW_SECONDS_RESET = CFG_BITS'(60);

  // Shared divider: 64-bit dividend shifted through, 48-bit divisor
  localparam int DIV_BITS     = 64;
  localparam int DIVISOR_BITS = 48;
  localparam int CNT_BITS     = 7;
  localparam logic [CNT_BITS-1:0] IDX_STEPS = CNT_BITS'(TIME_BITS);
  localparam logic [CNT_BITS-1:0] AVG_STEPS = CNT_BITS'(DIV_BITS);

  typedef struct packed {
    logic [TIME_BITS-1:0]        trade_time_ms;
    logic [FIELD_PRICE_BITS-1:0] trade_price;
    logic [FIELD_QTY_BITS-1:0]   trade_quantity;
  } trade_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]        window_start_ms;
    logic                        opens_window;
    logic [FIELD_PRICE_BITS-1:0] open_price;
    logic [FIELD_PRICE_BITS-1:0] high_price;
    logic [FIELD_PRICE_BITS-1:0] low_price;
    logic [FIELD_PRICE_BITS-1:0] close_price;
    logic [QSUM_BITS-1:0]        total_quantity;
    logic [TALLY_BITS-1:0]       trades_in_window;
    logic [FIELD_PRICE_BITS-1:0] average_price;
  } bar_t;

  typedef struct packed {
    logic                    start;
    logic [CNT_BITS-1:0]     steps;
    logic [DIV_BITS-1:0]     dividend;
    logic [DIVISOR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DIV_BITS-1:0]     quotient;
    logic [DIVISOR_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

@@ rtl/core/twba_divider.sv @@
// ----------------------------------------------------------------------------
// twba_divider
// Restoring divider, one quotient bit per cycle. The dividend is taken from
// the top of a 64-bit shift register for the requested number of steps;
// done pulses for one cycle with quotient and remainder stable after it.
// ----------------------------------------------------------------------------
module twba_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  twba_pkg::div_req_t div_req,
  output twba_pkg::div_rsp_t div_rsp
);
  import twba_pkg::*;

  logic [DIV_BITS-1:0]     q_r;
  logic [DIVISOR_BITS-1:0] rem_r;
  logic [DIVISOR_BITS-1:0] dsr_r;
  logic [CNT_BITS-1:0]     cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [DIVISOR_BITS+1:0] trial;
  logic                    fits;

  assign trial = {1'b0, rem_r, q_r[DIV_BITS-1]} - {2'b00, dsr_r};
  assign fits  = ~trial[DIVISOR_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        q_r    <= div_req.dividend;
        rem_r  <= '0;
        dsr_r  <= div_req.divisor;
        cnt_r  <= div_req.steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // keep the difference when the divisor fits, else shift the bit in
        rem_r <= fits ? trial[DIVISOR_BITS-1:0] : {rem_r[DIVISOR_BITS-2:0], q_r[DIV_BITS-1]};
        q_r   <= {q_r[DIV_BITS-2:0], fits};
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.done      = done_r;
  assign div_rsp.quotient  = q_r;
  assign div_rsp.remainder = rem_r;

endmodule

@@ rtl/core/trade_window_bar_aggregator.sv @@
// ----------------------------------------------------------------------------
// trade_window_bar_aggregator
// Running OHLCV bar per time window with volume-weighted average price.
//
//   channel  ports                          direction
//   in       in_valid / in_stall / in_data  trade into block
//   out      out_valid / out_stall / out_data  bar out of block
//   cfg      cfg_wr_en / cfg_wr_data        window length in seconds
//
// One trade occupies the block from its transfer until its bar is loaded
// into the output register: a 48-step divide for the window index, a 64-step
// divide for the average price and the sequencer states in between.
// With a zero quantity sum the average divide is skipped.
// The single shared restoring divider performs both divides.
// Reset (rst_n low, synchronous) clears the bar and sets the window to 60 s.
// A new trade is taken while the previous bar waits in the output register;
// the sequencer holds in its last state until that bar is transferred.
// ----------------------------------------------------------------------------
module trade_window_bar_aggregator #(
  parameter int PRICE_BITS    = twba_pkg::DEF_PRICE_BITS,
  parameter int QUANTITY_BITS = twba_pkg::DEF_QUANTITY_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  twba_pkg::trade_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output twba_pkg::bar_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [twba_pkg::CFG_BITS-1:0] cfg_wr_data
);
  import twba_pkg::*;

  localparam int PROD_BITS = PRICE_BITS + QUANTITY_BITS;
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_ACC,
    S_AVG_GO,
    S_AVG,
    S_OUT
  } state_t;

  state_t state_r;

  logic [CFG_BITS-1:0]      win_sec_r;
  logic [TIME_BITS-1:0]     t_r;
  logic [PRICE_BITS-1:0]    price_r;
  logic [QUANTITY_BITS-1:0] qty_r;
  logic [NOTIONAL_BITS-1:0] prod_r;
  logic                     have_r;
  logic [TIME_BITS-1:0]     win_idx_r;
  logic [PRICE_BITS-1:0]    first_r;
  logic [PRICE_BITS-1:0]    max_r;
  logic [PRICE_BITS-1:0]    min_r;
  logic [QSUM_BITS-1:0]     qsum_r;
  logic [NOTIONAL_BITS-1:0] notional_r;
  logic [TALLY_BITS-1:0]    tally_r;
  logic                     opens_r;
  logic [TIME_BITS-1:0]     wstart_r;
  logic [PRICE_BITS-1:0]    avg_r;
  logic                     out_valid_r;
  bar_t                     out_data_r;

  logic                     in_xfer;
  logic                     out_load;
  logic [CFG_BITS-1:0]      win_sec;
  logic [WIN_MS_BITS-1:0]   win_ms;
  logic [PROD_BITS-1:0]     prod_w;
  logic [QSUM_BITS:0]       qsum_add;
  logic [NOTIONAL_BITS:0]   notional_add;
  logic                     opens;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // zero length counts as one second
  assign win_sec = (win_sec_r == '0) ? CFG_BITS'(1) : win_sec_r;
  assign win_ms  = WIN_MS_BITS'(win_sec * WIN_MS_BITS'(MS_PER_SECOND));

  assign prod_w       = price_r * qty_r;
  assign qsum_add     = {1'b0, qsum_r} + (QSUM_BITS + 1)'(qty_r);
  assign notional_add = {1'b0, notional_r} + {1'b0, prod_r};
  assign opens        = !have_r || (div_rsp.quotient[TIME_BITS-1:0] != win_idx_r);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.steps    = IDX_STEPS;
    div_req.dividend = {in_data.trade_time_ms, (DIV_BITS - TIME_BITS)'(0)};
    div_req.divisor  = DIVISOR_BITS'(win_ms);
    if (state_r == S_IDLE) begin
      div_req.start = in_xfer;
    end else begin
      div_req.start    = (state_r == S_AVG_GO) && (qsum_r != '0);
      div_req.steps    = AVG_STEPS;
      div_req.dividend = notional_r;
      div_req.divisor  = qsum_r;
    end
  end

  twba_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_sec_r   <= WINDOW_SECONDS_RESET;
      have_r      <= 1'b0;
      win_idx_r   <= '0;
      first_r     <= '0;
      max_r       <= '0;
      min_r       <= '0;
      qsum_r      <= '0;
      notional_r  <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_sec_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            t_r     <= in_data.trade_time_ms;
            price_r <= in_data.trade_price[PRICE_BITS-1:0];
            qty_r   <= in_data.trade_quantity[QUANTITY_BITS-1:0];
            state_r <= S_IDX;
          end
        end
        S_IDX: begin
          prod_r <= NOTIONAL_BITS'(prod_w);
          if (div_rsp.done) begin
            opens_r  <= opens;
            wstart_r <= t_r - div_rsp.remainder[TIME_BITS-1:0];
            if (opens) begin
              have_r     <= 1'b1;
              win_idx_r  <= div_rsp.quotient[TIME_BITS-1:0];
              first_r    <= price_r;
              max_r      <= price_r;
              min_r      <= price_r;
              qsum_r     <= '0;
              notional_r <= '0;
              tally_r    <= '0;
            end
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (price_r > max_r) begin
            max_r <= price_r;
          end
          if (price_r < min_r) begin
            min_r <= price_r;
          end
          // saturate both sums and the count
          qsum_r     <= qsum_add[QSUM_BITS] ? '1 : qsum_add[QSUM_BITS-1:0];
          notional_r <= notional_add[NOTIONAL_BITS] ? '1 : notional_add[NOTIONAL_BITS-1:0];
          if (tally_r != '1) begin
            tally_r <= tally_r + TALLY_BITS'(1);
          end
          state_r <= S_AVG_GO;
        end
        S_AVG_GO: begin
          if (qsum_r == '0) begin
            avg_r   <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            avg_r   <= (|div_rsp.quotient[DIV_BITS-1:PRICE_BITS]) ? PRICE_MAX
                       : div_rsp.quotient[PRICE_BITS-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the previous bar has been transferred
          if (out_load) begin
            out_data_r.window_start_ms  <= wstart_r;
            out_data_r.opens_window     <= opens_r;
            out_data_r.open_price       <= FIELD_PRICE_BITS'(first_r);
            out_data_r.high_price       <= FIELD_PRICE_BITS'(max_r);
            out_data_r.low_price        <= FIELD_PRICE_BITS'(min_r);
            out_data_r.close_price      <= FIELD_PRICE_BITS'(price_r);
            out_data_r.total_quantity   <= qsum_r;
            out_data_r.trades_in_window <= tally_r;
            out_data_r.average_price    <= FIELD_PRICE_BITS'(avg_r);
            state_r                     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_IDX || state_r == S_AVG))
    else $error("divider finished outside a wait state");

  a_price_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.low_price <= out_data.close_price &&
                   out_data.close_price <= out_data.high_price))
    else $error("bar close outside low/high range");

  a_new_bar_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.opens_window) |-> (out_data.trades_in_window == TALLY_BITS'(1)))
    else $error("new bar does not start with one trade");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("second trade taken while one is in progress");
`endif

endmodule
